/* rtl/tbpfs_pkg.sv */
// Package for the two-bank priority run queue.
// Sizes, command and status codes, controller-to-datapath command struct.
`timescale 1ns / 1ps
package tbpfs_pkg;
  localparam int NUM_PRIO  = 32;
  localparam int CAPACITY  = 64;
  localparam int ID_WIDTH  = 16;
  localparam int PRIO_W    = $clog2(NUM_PRIO);
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int QIDX_W    = PRIO_W + 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_PRIO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load;    // capture request, decide, read head/tail
    logic fetch;   // read slot id and link at the queue head
    logic commit;  // update state, build result
  } ctl_t;

  typedef struct packed {
    logic res_valid;
  } sts_t;
endpackage

/* rtl/two_bank_priority_fifo_scheduler.sv */
// Two-bank priority run queue: push, pop or peek one request at a time.
// Channels: in_valid_i/in_ready_o carry command_i, task_id_i, priority_req_i;
// out_valid_o/out_ready_i carry one result per request.
// Each request passes through a load step that picks the free slot and the
// lowest nonempty priority and reads head/tail, a fetch step that reads the
// head slot's id and link, and a commit step that updates memories and bitmaps.
// A new request is not accepted until the previous one has committed.
// A new request is accepted while a previous result still waits.
// If the receiver stalls, the next request waits in the commit step until the
// output register is taken.
// Reset empties both banks, marks all slots free and selects bank 0 active.
// Slot, link, head and tail memories are not cleared; their contents are only
// used for nonempty queues.
// Uses tbpfs_pkg, tbpfs_ctrl, tbpfs_datapath.
`timescale 1ns / 1ps
module two_bank_priority_fifo_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] task_id_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [15:0] out_task_id_o,
  output logic [7:0]  out_priority_o,
  output logic [1:0]  status_o,
  output logic [6:0]  active_count_o,
  output logic [6:0]  expired_count_o
);
  tbpfs_pkg::ctl_t ctl;
  tbpfs_pkg::sts_t sts;

  tbpfs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  tbpfs_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .command_i, .task_id_i, .priority_req_i,
    .out_ready_i, .sts_o(sts), .found_o, .out_task_id_o, .out_priority_o,
    .status_o, .active_count_o, .expired_count_o
  );

  assign out_valid_o = sts.res_valid;
endmodule

/* rtl/tbpfs_datapath.sv */
// Datapath: slot store, link, head/tail memories, bitmaps and counters.
// Uses tbpfs_pkg; steered by tbpfs_ctrl through ctl_t.
`timescale 1ns / 1ps
module tbpfs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbpfs_pkg::ctl_t             ctl_i,
  input  logic [1:0]                  command_i,
  input  logic [15:0]                 task_id_i,
  input  logic [7:0]                  priority_req_i,
  input  logic                        out_ready_i,
  output tbpfs_pkg::sts_t             sts_o,
  output logic                        found_o,
  output logic [15:0]                 out_task_id_o,
  output logic [7:0]                  out_priority_o,
  output logic [1:0]                  status_o,
  output logic [6:0]                  active_count_o,
  output logic [6:0]                  expired_count_o
);
  localparam int SW = tbpfs_pkg::SLOT_W;
  localparam int PW = tbpfs_pkg::PRIO_W;
  localparam int QW = tbpfs_pkg::QIDX_W;
  localparam int CW = tbpfs_pkg::CNT_W;
  localparam int NP = tbpfs_pkg::NUM_PRIO;
  localparam int CAP = tbpfs_pkg::CAPACITY;
  localparam int IW = tbpfs_pkg::ID_WIDTH;

  logic [IW-1:0] store_mem [CAP];
  logic [SW-1:0] link_mem  [CAP];
  logic [SW-1:0] head_mem  [2*NP];
  logic [SW-1:0] tail_mem  [2*NP];

  logic [CAP-1:0] free_q;
  logic [NP-1:0]  ne_q [2];
  logic           act_q;
  logic [CW-1:0]  cnt_q [2];

  // latched request and stage-1 decisions
  logic [1:0]    cmd_q;
  logic [IW-1:0] id_q;
  logic [PW-1:0] prio_q;
  logic          bad_q, full_q, hit_q, wasne_q;
  logic [SW-1:0] slot_q;
  logic          bank_q;
  logic [SW-1:0] head_rd_q, tail_rd_q;

  // stage-1 combinational decisions
  logic          is_push, is_take, swap;
  logic          a_bank, e_bank;
  logic          free_any, ne_any;
  logic [SW-1:0] free_idx;
  logic [PW-1:0] ne_idx;
  logic [PW-1:0] push_p;
  logic [QW-1:0] rd_idx;

  assign is_push = command_i == tbpfs_pkg::CMD_PUSH;
  assign is_take = command_i == tbpfs_pkg::CMD_POP || command_i == tbpfs_pkg::CMD_PEEK;
  assign swap    = is_take && cnt_q[act_q] == '0 && cnt_q[!act_q] != '0;
  assign a_bank  = act_q ^ swap;
  assign e_bank  = !act_q;
  assign push_p  = priority_req_i[PW-1:0];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
    ne_any = 1'b0;
    ne_idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (ne_q[a_bank][i]) begin
        ne_any = 1'b1;
        ne_idx = PW'(i);
      end
    end
    rd_idx = is_push ? {e_bank, push_p} : {a_bank, ne_idx};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      head_rd_q <= head_mem[rd_idx];
      tail_rd_q <= tail_mem[rd_idx];
      cmd_q  <= command_i;
      id_q   <= IW'(task_id_i);
      prio_q <= is_push ? push_p : ne_idx;
      bad_q  <= {8'd0, priority_req_i} >= 16'(NP);
      full_q <= !free_any;
      hit_q  <= ne_any && cnt_q[a_bank] != '0;
      wasne_q <= ne_q[e_bank][push_p];
      slot_q <= free_idx;
      bank_q <= is_push ? e_bank : a_bank;
    end
  end

  logic do_push, do_take, do_pop, last;
  assign do_push = cmd_q == tbpfs_pkg::CMD_PUSH && !bad_q && !full_q;
  assign do_take = (cmd_q == tbpfs_pkg::CMD_POP || cmd_q == tbpfs_pkg::CMD_PEEK) && hit_q;
  assign do_pop  = do_take && cmd_q == tbpfs_pkg::CMD_POP;
  assign last    = head_rd_q == tail_rd_q;

  // head entry id and link, read in the fetch step before the commit
  logic [IW-1:0] rd_id_q;
  logic [SW-1:0] rd_link_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.fetch) begin
      rd_id_q   <= store_mem[head_rd_q];
      rd_link_q <= link_mem[head_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      if (do_push) begin
        store_mem[slot_q] <= id_q;
        tail_mem[{bank_q, prio_q}] <= slot_q;
        if (wasne_q) link_mem[tail_rd_q] <= slot_q;
        else head_mem[{bank_q, prio_q}] <= slot_q;
      end else if (do_pop && !last) begin
        head_mem[{bank_q, prio_q}] <= rd_link_q;
      end
      out_task_id_o  <= do_take ? 16'(rd_id_q) : 16'd0;
      out_priority_o <= do_take ? 8'(prio_q) : 8'd0;
      found_o        <= do_take;
      status_o       <= (cmd_q != tbpfs_pkg::CMD_PUSH) ? tbpfs_pkg::ST_OK :
                        bad_q ? tbpfs_pkg::ST_PRIO :
                        full_q ? tbpfs_pkg::ST_FULL : tbpfs_pkg::ST_OK;
    end
  end

  logic [CW-1:0] nc0, nc1;
  logic          nact;
  always_comb begin
    nc0 = cnt_q[0];
    nc1 = cnt_q[1];
    if (do_push) begin
      if (bank_q) nc1 = nc1 + 1'b1; else nc0 = nc0 + 1'b1;
    end else if (do_pop) begin
      if (bank_q) nc1 = nc1 - 1'b1; else nc0 = nc0 - 1'b1;
    end
    // a take always leaves the active bank as the one it read
    nact = (cmd_q == tbpfs_pkg::CMD_POP || cmd_q == tbpfs_pkg::CMD_PEEK) && hit_q
           ? bank_q : act_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      ne_q[0] <= '0;
      ne_q[1] <= '0;
      act_q <= 1'b0;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      sts_o.res_valid <= 1'b0;
      active_count_o <= '0;
      expired_count_o <= '0;
    end else begin
      if (ctl_i.commit) begin
        if (do_push) begin
          free_q[slot_q] <= 1'b0;
          ne_q[bank_q][prio_q] <= 1'b1;
        end else if (do_pop) begin
          free_q[head_rd_q] <= 1'b1;
          if (last) ne_q[bank_q][prio_q] <= 1'b0;
        end
        act_q <= nact;
        cnt_q[0] <= nc0;
        cnt_q[1] <= nc1;
        active_count_o  <= 7'(nact ? nc1 : nc0);
        expired_count_o <= 7'(nact ? nc0 : nc1);
        sts_o.res_valid <= 1'b1;
      end else if (out_ready_i) begin
        sts_o.res_valid <= 1'b0;
      end
    end
  end
endmodule

/* rtl/tbpfs_ctrl.sv */
// Controller: accept, fetch and commit sequencing.
// Uses tbpfs_pkg; drives tbpfs_datapath through ctl_t.
`timescale 1ns / 1ps
module tbpfs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  input  tbpfs_pkg::sts_t sts_i,
  output tbpfs_pkg::ctl_t ctl_o
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  logic [1:0] state_q, state_d;

  // output register is free when empty or taken this cycle
  logic out_free;
  assign out_free   = !sts_i.res_valid || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;
  assign ctl_o.load   = in_valid_i && in_ready_o;
  assign ctl_o.fetch  = state_q == S_FETCH;
  assign ctl_o.commit = state_q == S_EXEC && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (ctl_o.load) state_d = S_FETCH;
      S_FETCH: state_d = S_EXEC;
      S_EXEC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule

/* rtl/tbpfs_checker.sv */
// Port-level checker for the run queue, bound to the top level.
// Uses tbpfs_pkg codes.
`timescale 1ns / 1ps
module tbpfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        found_o,
  input logic [1:0]  status_o,
  input logic [6:0]  active_count_o,
  input logic [6:0]  expired_count_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_no_ready_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("two requests in flight");
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == tbpfs_pkg::ST_OK) else $error("found with error");
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> active_count_o != 7'd0 || expired_count_o != 7'd0 ||
    status_o == tbpfs_pkg::ST_OK) else $error("bad count");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 8'(active_count_o) + 8'(expired_count_o) <= 8'(tbpfs_pkg::CAPACITY))
    else $error("count exceeds capacity");
endmodule

bind two_bank_priority_fifo_scheduler tbpfs_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .found_o, .status_o, .active_count_o, .expired_count_o
);
